// ----- sv/assert_macros.svh -----
// assertion helpers used by the rtl controller
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/sha_pkg.sv -----
// shared types, constants and functions of the sha-256 hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

  localparam int unsigned BLOCK_WORDS = 16;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // source of the byte written into the block
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_P80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic        load_in;
    logic        put;
    byte_sel_e   sel;
    logic [2:0]  byte_idx;
    logic        round;
    logic [5:0]  rnd_idx;
    logic        fold;
    logic        reinit;
    logic [2:0]  out_idx;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic        wrap;
    logic [5:0]  next_fill;
    logic [2:0]  count;
    logic        last;
  } stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sha_dp.sv -----
// datapath: input hold, block buffer and schedule, rounds, chaining words, length
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha_dp import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_word_i,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  output logic [31:0]      digest_word_o
);

  localparam int unsigned FillW = $clog2(BLOCK_WORDS * 4);
  localparam int unsigned IdxW  = $clog2(BLOCK_WORDS);

  logic [31:0]      word_q;
  logic [2:0]       count_q;
  logic             last_q;
  logic [31:0]      w_q [BLOCK_WORDS];
  logic [31:0]      h_q [8];
  logic [31:0]      v_q [8];
  logic [FillW-1:0] fill_q;
  logic [63:0]      len_q;

  logic [7:0]       byte_d;
  logic [IdxW-1:0]  widx;
  logic [31:0]      w_new, t1, t2;

  // byte source select
  always_comb begin
    unique case (cmd_i.sel)
      SEL_DATA: byte_d = word_q[(3 - cmd_i.byte_idx[1:0]) * 8 +: 8];
      SEL_P80:  byte_d = PAD_BYTE;
      SEL_ZERO: byte_d = 8'h00;
      default:  byte_d = len_q[(7 - cmd_i.byte_idx) * 8 +: 8];
    endcase
  end

  assign widx = fill_q[FillW-1:2];

  // schedule word and round terms
  assign w_new = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
               + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
  assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(cmd_i.rnd_idx) + w_q[0];
  assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // input hold on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      word_q  <= data_word_i;
      count_q <= (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
      last_q  <= last_word_i;
    end
  end

  // block buffer, doubling as the schedule window during rounds
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      w_q[widx][(3 - fill_q[1:0]) * 8 +: 8] <= byte_d;
    end else if (cmd_i.round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) w_q[i] <= w_q[i + 1];
      w_q[BLOCK_WORDS - 1] <= w_new;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.put && (&fill_q)) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // chaining words, fill position and bit length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
      fill_q <= '0;
      len_q  <= '0;
    end else if (cmd_i.reinit) begin
      for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.put) begin
        fill_q <= fill_q + 1'b1;
        if (cmd_i.sel == SEL_DATA) len_q <= len_q + 64'd8;
      end
    end
  end

  assign stat_o.wrap      = &fill_q;
  assign stat_o.next_fill = 6'(fill_q + 1'b1);
  assign stat_o.count     = count_q;
  assign stat_o.last      = last_q;
  assign digest_word_o    = h_q[cmd_i.out_idx];

endmodule

`default_nettype wire

// ----- sv/sha_ctrl.sv -----
// controller: byte feed, padding, round and digest sequencing
// depends on sha_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sha_ctrl import sha_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUT   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [2:0] PH_DATA  = 3'd0;
  localparam logic [2:0] PH_P80   = 3'd1;
  localparam logic [2:0] PH_ZERO  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_IDLE  = 3'd4;
  localparam logic [2:0] PH_OUT   = 3'd5;

  localparam logic [5:0] LenPos = 6'd56;

  logic [2:0] state_q, state_d;
  logic [2:0] ph_q, ph_d;
  logic [2:0] ci_q, ci_d;
  logic [5:0] rc_q, rc_d;
  logic [2:0] oi_q, oi_d;

  // state after a phase decision
  function automatic logic [2:0] dispatch(input logic [2:0] ph);
    priority if (ph == PH_IDLE) dispatch = ST_IDLE;
    else if (ph == PH_OUT)      dispatch = ST_OUT;
    else                        dispatch = ST_PUT;
  endfunction

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    ci_d    = ci_q;
    rc_d    = rc_q;
    oi_d    = oi_q;
    cmd_o   = '0;
    cmd_o.sel      = SEL_DATA;
    cmd_o.byte_idx = ci_q;
    cmd_o.rnd_idx  = rc_q;
    cmd_o.out_idx  = oi_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          ci_d    = '0;
          ph_d    = PH_DATA;
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        // first cycle after transfer may find an empty word
        if (ph_q == PH_DATA && stat_i.count == 3'd0) begin
          ph_d    = stat_i.last ? PH_P80 : PH_IDLE;
          state_d = dispatch(ph_d);
        end else begin
          cmd_o.put = 1'b1;
          unique case (ph_q)
            PH_DATA: begin
              cmd_o.sel = SEL_DATA;
              if (ci_q == stat_i.count - 3'd1) begin
                ph_d = stat_i.last ? PH_P80 : PH_IDLE;
              end else begin
                ci_d = ci_q + 3'd1;
              end
            end
            PH_P80, PH_ZERO: begin
              cmd_o.sel = (ph_q == PH_P80) ? SEL_P80 : SEL_ZERO;
              ci_d = '0;
              ph_d = (stat_i.next_fill == LenPos) ? PH_LEN : PH_ZERO;
            end
            default: begin
              cmd_o.sel = SEL_LEN;
              if (ci_q == 3'd7) ph_d = PH_OUT;
              else ci_d = ci_q + 3'd1;
            end
          endcase
          if (stat_i.wrap) begin
            rc_d    = '0;
            state_d = ST_ROUND;
          end else begin
            state_d = dispatch(ph_d);
          end
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rc_d = rc_q + 6'd1;
        if (&rc_q) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        oi_d    = '0;
        state_d = dispatch(ph_q);
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          oi_d = oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_IDLE;
      ci_q    <= '0;
      rc_q    <= '0;
      oi_q    <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      ci_q    <= ci_d;
      rc_q    <= rc_d;
      oi_q    <= oi_d;
    end
  end

  `SHA_ASSERT_NEXT(a_rounds_end, state_q == ST_ROUND && (&rc_q), state_q == ST_FOLD)
  `SHA_ASSERT_NEXT(a_digest_end, out_valid_o && out_ready_i && oi_q == 3'd7, state_q == ST_IDLE)
  `SHA_ASSERT(a_one_side, !(in_ready_o && out_valid_o))

endmodule

`default_nettype wire

// ----- sv/sha256_message_hasher.sv -----
// channel  | signals                                       | direction
// input    | in_valid_i, in_ready_o, data_word_i,          | into block
//          | byte_count_i, last_word_i                     |
// output   | out_valid_o, out_ready_i, digest_word_o,      | out of block
//          | word_index_o, last_of_digest_o                |
// one input word at a time: each valid byte is written in turn; an empty word writes no byte
// each full 64-byte block goes through the shared round unit round by round, then one fold
// a last word adds 9 to 72 padding bytes, one or two compressions, then 8 digest words
// reset restores the initial hash values at once; no clearing pass
// input stalls while busy; the digest words wait on out_ready_i
// top level of the sha-256 hasher; depends on sha_pkg, sha_ctrl, sha_dp
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_hasher import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_of_digest_o
);

  cmd_t  cmd;
  stat_t stat;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_word_i   (data_word_i),
    .byte_count_i  (byte_count_i),
    .last_word_i   (last_word_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .digest_word_o (digest_word_o)
  );

  // digest word position
  assign word_index_o     = cmd.out_idx;
  assign last_of_digest_o = (cmd.out_idx == 3'd7);

endmodule

`default_nettype wire

// ----- tb/sv/sha256_digest_checker.sv -----
// checker for the sha-256 hasher: watches both channels, predicts digests, compares
// depends on sha_pkg for the initial hash values and the pad byte
`timescale 1ns / 1ps
`default_nettype none

module sha256_digest_checker import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_word_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] digest_word_i,
  input  wire logic [2:0]  word_index_i,
  input  wire logic        last_of_digest_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  digest_t     digest_q [$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = digest_q.size();

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = '0;
    bit_len = '0;
  endtask

  // one 64-round compression of the filled block into the chaining words
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic append_byte(input logic [7:0] b);
    if (fill[1:0] == 2'd0) blk[fill[5:2]] = '0;
    blk[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] = b;
    if (fill == 6'd63) compress();
    fill = fill + 6'd1;
  endtask

  // absorb one word; on the last word pad and queue the eight digest words
  task automatic absorb_word(input logic [31:0] data, input logic [2:0] cnt, input logic lst);
    int n;
    logic [63:0] len;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    for (int i = 0; i < n; i++) begin
      append_byte(data[31 - 8 * i -: 8]);
      bit_len += 64'd8;
    end
    if (lst) begin
      len = bit_len;
      append_byte(PAD_BYTE);
      while (fill != 6'd56) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(len[63 - 8 * i -: 8]);
      for (int i = 0; i < 8; i++) digest_q.push_back({chain[i], 3'(i), i == 7});
      restart_message();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial begin
    fails = 0;
    restart_message();
  end

  // sample transfers at the rising edge
  always @(posedge clk_i) begin
    digest_t exp_d;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) absorb_word(data_word_i, byte_count_i, last_word_i);
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", digest_word_i, '0);
        end else begin
          exp_d = digest_q.pop_front();
          if (digest_word_i !== exp_d.word)
            report_mismatch("digest_word", digest_word_i, exp_d.word);
          if (word_index_i !== exp_d.idx)
            report_mismatch("word_index", 32'(word_index_i), 32'(exp_d.idx));
          if (last_of_digest_i !== exp_d.last)
            report_mismatch("last_of_digest", 32'(last_of_digest_i), 32'(exp_d.last));
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// top of the sha-256 hasher test: clock, reset, message stimulus and verdict
// depends on sha_pkg, sha256_message_hasher and sha256_digest_checker
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int unsigned IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] data_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_of_digest_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  int unsigned word_total;

  always #5 clk_i = ~clk_i;

  sha256_message_hasher dut (.*);

  sha256_digest_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_word_i, .byte_count_i,
    .last_word_i, .out_valid_i(out_valid_o), .out_ready_i, .digest_word_i(digest_word_o),
    .word_index_i(word_index_o), .last_of_digest_i(last_of_digest_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("sha256_message_hasher test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one word transfer, with a random idle gap before it; valid drops only while idling
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_word_i  <= data;
    byte_count_i <= cnt;
    last_word_i  <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    word_total++;
  endtask

  // random message: mostly full words, sometimes partial or zero-count words
  task automatic send_message(input int words);
    logic [2:0] cnt;
    for (int i = 0; i < words; i++) begin
      case ($urandom_range(9))
        0:       cnt = 3'($urandom_range(7));
        1, 2:    cnt = 3'($urandom_range(1, 3));
        default: cnt = 3'd4;
      endcase
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  initial begin
    quiet_cycles   = 0;
    word_total     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty message, extremes of data, saturated counts, zero-count words
    send_word('0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h00000000, 3'd7, 1'b1);
    send_word(32'haaaaaaaa, 3'd0, 1'b0);
    send_word(32'h55555555, 3'd5, 1'b0);
    send_word(32'h12345678, 3'd1, 1'b0);
    send_word(32'h9abcdef0, 3'd2, 1'b1);
    // exactly 56 bytes forces the length into an extra block
    for (int i = 0; i < 14; i++) send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'h0, 3'd0, 1'b1);

    // random messages across the idling phases, lengths up to about two blocks
    for (int phase = 0; phase < 4; phase++) begin
      set_idling(phase);
      while (word_total < 23 + (phase + 1) * 45) begin
        if ($urandom_range(3) == 0) send_message($urandom_range(0, 34));
        else send_message($urandom_range(0, 17));
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("sha256_message_hasher test passed");
    end else begin
      $display("sha256_message_hasher test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/sha_pkg.sv
sv/sha_dp.sv
sv/sha_ctrl.sv
sv/sha256_message_hasher.sv
tb/sv/sha256_digest_checker.sv
tb/sv/testbench.sv
